FILE: src/bitmap_block_allocator_top_macros.svh
// Assertion macros for the bitmap block allocator.
// Used by bitmap_block_allocator_top; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bba check failed");
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bba check failed");
`else
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/bba_pkg.sv
// Shared constants, types and helpers for the bitmap block allocator.
// No dependencies.
package bba_pkg;

   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int BLK_W      = 12;
   localparam int LIM_W      = 13;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_OUT_OF_BLOCKS = 2'd1,
      ST_FREEING_FREE  = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // index of the lowest set bit; 0 when none is set
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: src/bitmap_block_allocator_top.sv
// Bitmap block allocator: used-bit map in one word memory, first-fit scan.
// Depends on bba_pkg and bitmap_block_allocator_top_macros.svh.
//
// Usage:
//   req channel (req_valid/req_ready): req_func 0 allocates the lowest free
//   block below min(total_blocks, pool size); 1 frees req_block_number.
//   rsp channel (rsp_valid/rsp_ready): one item per request, with
//   rsp_block_number_res and rsp_status (0 ok, 1 out of blocks, 2 freeing a
//   free block). csr_wr_en/csr_wr_data set total_blocks; write only when idle.
//   A free does one memory read, then one check and write back, before its
//   result is registered. An allocate reads one 32-bit map word per cycle
//   from word 0 upward, scanning at most 128 words for the 4096-block
//   pool. The single read port of the map memory sets this pace.
//   A new request is taken once the previous one has finished its scan, even
//   while its result still waits in the output register; the next result
//   then holds in the scan state until rsp_ready frees the register.
//   Reset clears total_blocks to 4096 and marks every map word as all free
//   through per-word valid flags, so the block is usable the cycle after.
`include "bitmap_block_allocator_top_macros.svh"

module bitmap_block_allocator_top
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [BLK_W-1:0]     req_block_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BLK_W-1:0]     rsp_block_number_res,
   output logic [1:0]           rsp_status,
   input  logic                 csr_wr_en,
   input  logic [LIM_W-1:0]     csr_wr_data
);

   // map memory and per-word valid flags
   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   state_type            state_ff, state_in;
   logic [LIM_W-1:0]     total_ff;
   logic                 func_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic [ADDR_W-1:0]    word_ff, word_in;

   logic                 rsp_valid_ff;
   logic [BLK_W-1:0]     rsp_block_ff;
   status_type           rsp_status_ff;

   // datapath signals
   logic [LIM_W-1:0]     lim;
   logic [LIM_W-1:0]     base;
   logic [LIM_W-1:0]     next_base;
   logic [LIM_W-1:0]     remaining;
   logic [WORD_BITS-1:0] word_q;
   logic [WORD_BITS-1:0] allowed;
   logic [WORD_BITS-1:0] cand;
   logic [BIT_W-1:0]     found_idx;
   logic                 found;
   logic                 more_words;
   logic                 slot_free;
   logic                 done;
   status_type           res_status;
   logic [BLK_W-1:0]     res_block;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 req_fire;

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign lim = (total_ff > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : total_ff;
   assign base      = {1'b0, word_ff, {BIT_W{1'b0}}};
   assign next_base = base + LIM_W'(WORD_BITS);
   assign remaining = lim - base;
   assign word_q    = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         allowed[i] = (base < lim) && (LIM_W'(i) < remaining);
      end
   end

   assign cand       = ~word_q & allowed;
   assign found      = |cand;
   assign found_idx  = first_set(cand);
   assign more_words = (word_ff != ADDR_W'(MAP_WORDS - 1)) && (next_base < lim);

   // result of the word now under check
   always_comb begin
      done       = 1'b0;
      res_status = ST_OK;
      res_block  = '0;
      wr_en      = 1'b0;
      wr_data    = word_q;
      if (func_ff == FUNC_FREE) begin
         done = 1'b1;
         if (word_q[bit_ff]) begin
            wr_en   = 1'b1;
            wr_data = word_q & ~(WORD_BITS'(1) << bit_ff);
         end else begin
            res_status = ST_FREEING_FREE;
         end
      end else if (found) begin
         done      = 1'b1;
         wr_en     = 1'b1;
         wr_data   = word_q | (WORD_BITS'(1) << found_idx);
         res_block = BLK_W'({word_ff, found_idx});
      end else if (!more_words) begin
         done       = 1'b1;
         res_status = ST_OUT_OF_BLOCKS;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (done && slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = word_ff;
      word_in   = word_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_en   = 1'b1;
               rd_addr = (req_func == FUNC_FREE) ? req_block_number[BLK_W-1:BIT_W] : '0;
               word_in = rd_addr;
            end
         end
         S_SCAN: begin
            // advance to the next word while nothing has been found
            if (!done) begin
               rd_en   = 1'b1;
               rd_addr = word_ff + ADDR_W'(1);
               word_in = rd_addr;
            end
         end
         default: ;
      endcase
   end

   // map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && done && slot_free && wr_en) begin
         mem[word_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == S_SCAN && done && slot_free && wr_en) begin
            word_valid_ff[word_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= word_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= LIM_W'(MAX_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (state_ff == S_SCAN && done && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (req_fire) begin
         func_ff <= req_func;
         bit_ff  <= req_block_number[BIT_W-1:0];
      end
      if (state_ff == S_SCAN && done && slot_free) begin
         rsp_block_ff  <= res_block;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_block_number_res = rsp_block_ff;
   assign rsp_status           = rsp_status_ff;

   `BBA_ASSERT_NEXT(a_accept_scans, clock, reset, req_fire, state_ff == S_SCAN)
   `BBA_ASSERT_SAME(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `BBA_ASSERT_SAME(a_nonok_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_block_number_res == '0)

endmodule

FILE: test/tb.sv
// Self-checking testbench for bitmap_block_allocator_top: directed rows, then random phases.
// Keeps a used-block map of its own to predict each reply that a directed row does not fix.
// Depends on bba_pkg and the allocator RTL.
module tb
   import bba_pkg::*;
();

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 140;
   localparam int PHASE_ITEMS  = 45;
   localparam int DIR_ROWS     = 24;
   localparam int PHASES       = 10;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_REQ_FIXED,
      ROW_SET_TOTAL
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      func_type         func;
      logic [BLK_W-1:0] blk;
      logic [BLK_W-1:0] want_blk;
      status_type       want_status;
      logic [LIM_W-1:0] total;
   } dir_row_type;

   typedef struct {
      logic [BLK_W-1:0] blk;
      status_type       status;
   } reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   func_type         req_func = FUNC_ALLOC;
   logic [BLK_W-1:0] req_block_number = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [BLK_W-1:0] rsp_block_number_res;
   logic [1:0]       rsp_status;
   logic             csr_wr_en = 1'b0;
   logic [LIM_W-1:0] csr_wr_data = '0;

   logic [MAX_BLOCKS-1:0] block_used = '0;
   logic [LIM_W-1:0]      pool_total = LIM_W'(4096);
   reply_type             owed_replies [$];
   int                    errors = 0;
   int                    burst_left = 0;
   int                    ready_run = 0;
   int                    quiet_cycles = 0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd4095, 12'd1, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd0,    12'd0, ST_FREEING_FREE,  13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd4095, 12'd0, ST_FREEING_FREE,  13'd0},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'hAAA,  12'd0, ST_OK,            13'd0},
      '{ROW_SET_TOTAL, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd0,    12'd0, ST_OUT_OF_BLOCKS, 13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd1,    12'd0, ST_OK,            13'd0},
      '{ROW_SET_TOTAL, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd1},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd0,    12'd0, ST_OUT_OF_BLOCKS, 13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_SET_TOTAL, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd8191},
      '{ROW_REQ_FIXED, FUNC_ALLOC, 12'd0,    12'd1, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd2048, 12'd0, ST_FREEING_FREE,  13'd0},
      '{ROW_SET_TOTAL, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd33},
      '{ROW_REQ,       FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ,       FUNC_ALLOC, 12'h555,  12'd0, ST_OK,            13'd0},
      '{ROW_REQ,       FUNC_FREE,  12'd1,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ,       FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0},
      '{ROW_REQ_FIXED, FUNC_FREE,  12'd4094, 12'd0, ST_FREEING_FREE,  13'd0},
      '{ROW_SET_TOTAL, FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd4096},
      '{ROW_REQ,       FUNC_ALLOC, 12'd0,    12'd0, ST_OK,            13'd0}
   };

   logic [LIM_W-1:0] phase_totals [PHASES] = '{
      13'd37, 13'd1, 13'd64, 13'd0, 13'd8191, 13'd100, 13'd4096, 13'd4095, 13'd32, 13'd33
   };

   bitmap_block_allocator_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_block_number     (req_block_number),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_number_res (rsp_block_number_res),
      .rsp_status           (rsp_status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   // First fit over the used map below min(total, pool); free clears one bit.
   function automatic void apply_to_map(input func_type f, input logic [BLK_W-1:0] blk,
                                        output logic [BLK_W-1:0] res_blk,
                                        output status_type res_status);
      int lim;
      bit found;
      res_blk    = '0;
      res_status = ST_OUT_OF_BLOCKS;
      found      = 1'b0;
      lim = (int'(pool_total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_total);
      if (f == FUNC_ALLOC) begin
         for (int i = 0; i < lim && !found; i++) begin
            if (!block_used[i]) begin
               block_used[i] = 1'b1;
               res_blk       = BLK_W'(i);
               res_status    = ST_OK;
               found         = 1'b1;
            end
         end
      end else if (block_used[blk]) begin
         block_used[blk] = 1'b0;
         res_status      = ST_OK;
      end else begin
         res_status = ST_FREEING_FREE;
      end
   endfunction

   task automatic send_item(input func_type f, input logic [BLK_W-1:0] blk, input bit fixed,
                            input logic [BLK_W-1:0] want_blk, input status_type want_status);
      int gap;
      reply_type due;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_func         <= f;
      req_block_number <= blk;
      do @(posedge clock); while (!req_ready);
      apply_to_map(f, blk, due.blk, due.status);
      if (fixed) begin
         due.blk    = want_blk;
         due.status = want_status;
      end
      owed_replies.push_back(due);
   endtask

   // Drain every owed reply before touching the register.
   task automatic set_total(input logic [LIM_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      pool_total = value;
   endtask

   // Reply checker and receiver stall pattern.
   always @(posedge clock) begin
      reply_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            $error("unowed reply: block_number_res %0d status %0d",
                   rsp_block_number_res, rsp_status);
            errors++;
         end else begin
            due = owed_replies.pop_front();
            if (rsp_block_number_res !== due.blk) begin
               $error("block_number_res expected %0d actual %0d", due.blk,
                      rsp_block_number_res);
               errors++;
            end
            if (rsp_status !== due.status) begin
               $error("status expected %0d actual %0d", due.status, rsp_status);
               errors++;
            end
         end
      end
      if (ready_run == 0) begin
         if (!rsp_ready) begin
            rsp_ready <= 1'b1;
            ready_run = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 25);
         end else begin
            rsp_ready <= 1'b0;
            ready_run = $urandom_range(1, 8);
         end
      end else begin
         ready_run--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int alloc_pct;
      int roll;
      int start;
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_SET_TOTAL) begin
            set_total(dir_rows[i].total);
         end else begin
            send_item(dir_rows[i].func, dir_rows[i].blk, dir_rows[i].kind == ROW_REQ_FIXED,
                      dir_rows[i].want_blk, dir_rows[i].want_status);
         end
      end

      foreach (phase_totals[p]) begin
         set_total(phase_totals[p]);
         alloc_pct = $urandom_range(45, 80);
         repeat (PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
               send_item(FUNC_ALLOC, BLK_W'($urandom), 1'b0, '0, ST_OK);
            end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
               // free a block that is in use, wrapping from a random start; the start itself if none is
               start = $urandom_range(0, MAX_BLOCKS - 1);
               pick  = -1;
               for (int k = 0; k < MAX_BLOCKS && pick < 0; k++) begin
                  if (block_used[(start + k) % MAX_BLOCKS]) begin
                     pick = (start + k) % MAX_BLOCKS;
                  end
               end
               if (pick < 0) begin
                  pick = start;
               end
               send_item(FUNC_FREE, BLK_W'(pick), 1'b0, '0, ST_OK);
            end else begin
               send_item(FUNC_FREE, BLK_W'($urandom_range(0, MAX_BLOCKS - 1)), 1'b0, '0,
                         ST_OK);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
